### rtl/kbf_pkg.sv
`timescale 1ns / 1ps
package kbf_pkg;

  // membership table geometry
  localparam int TBL_AW      = 14;
  localparam int TBL_DEPTH   = 1 << TBL_AW;
  localparam int TBL_WORD_W  = 64;
  localparam int BIT_SEL_W   = 6;
  localparam int IDX_CODE_W  = TBL_AW + BIT_SEL_W;

  // queue between front and back
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = QPTR_W + 1;

  // stream field layout
  localparam int BASE_W      = 8;
  localparam int WL_W        = 4;
  localparam int S_TDATA_W   = 88;
  localparam int M_TDATA_W   = 8;

  localparam logic [WL_W-1:0] WL_RESET = 4'd10;

  // command codes carried on tuser
  localparam logic CMD_SEQ   = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // queue entry: a table write or a classified sequence character
  // for a table write the word address travels in fwd_idx
  typedef struct packed {
    logic                  is_write;
    logic                  lookup;
    logic                  last;
    logic [TBL_AW-1:0]     fwd_idx;
    logic [BIT_SEL_W-1:0]  fwd_bit;
    logic [TBL_AW-1:0]     rc_idx;
    logic [BIT_SEL_W-1:0]  rc_bit;
    logic [TBL_WORD_W-1:0] word;
  } kbf_entry_t;

endpackage

### rtl/kbf_front.sv
`timescale 1ns / 1ps
module kbf_front #(
  parameter int MAX_WORD_LENGTH = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kbf_pkg::WL_W-1:0]    cfg_wdata_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic                        command_i,
  input  logic [kbf_pkg::BASE_W-1:0]  base_i,
  input  logic                        last_i,
  input  logic [kbf_pkg::TBL_AW-1:0]  table_address_i,
  input  logic [kbf_pkg::TBL_WORD_W-1:0] table_word_i,
  output logic                        push_o,
  output kbf_pkg::kbf_entry_t         entry_o,
  input  logic                        full_i
);
  import kbf_pkg::*;

  localparam int KW  = 2 * MAX_WORD_LENGTH;
  localparam int KBW = $clog2(MAX_WORD_LENGTH + 1);
  localparam int CW  = (KW > IDX_CODE_W) ? KW : IDX_CODE_W;

  logic [WL_W-1:0] wl_q;
  logic [KW-1:0]   fwd_q, fwd_d;
  logic [KW-1:0]   rc_q, rc_d;
  logic [KBW-1:0]  vb_q, vb_d;

  logic [KBW-1:0]  k;
  logic [KW-1:0]   mask;
  logic            is_base;
  logic [1:0]      code;
  logic [KW-1:0]   fwd_n, rc_n;
  logic [KBW-1:0]  vb_n;
  logic [CW-1:0]   fwd_ext, rc_ext;
  logic            accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept;

  // word length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_RESET;
    end else if (cfg_we_i) begin
      wl_q <= cfg_wdata_i;
    end
  end

  // effective k and the 2k-bit mask
  always_comb begin
    if (wl_q == '0) begin
      k = KBW'(1);
    end else if (int'(wl_q) > MAX_WORD_LENGTH) begin
      k = KBW'(MAX_WORD_LENGTH);
    end else begin
      k = KBW'(wl_q);
    end
    for (int i = 0; i < KW; i++) begin
      mask[i] = (i < 2 * int'(k));
    end
  end

  // base decode, upper or lower case
  always_comb begin
    is_base = 1'b1;
    code    = 2'd0;
    unique case (base_i)
      8'h41, 8'h61: code = 2'd0;
      8'h43, 8'h63: code = 2'd1;
      8'h47, 8'h67: code = 2'd2;
      8'h54, 8'h74: code = 2'd3;
      default:      is_base = 1'b0;
    endcase
  end

  // rolling forward and reverse complement codes
  always_comb begin
    fwd_n = ((fwd_q << 2) | KW'(code)) & mask;
    rc_n  = (((rc_q & mask) >> 2) | (KW'(~code) << (2 * (int'(k) - 1)))) & mask;
    vb_n  = (vb_q < k) ? vb_q + 1'b1 : k;
  end

  // per-read state update
  always_comb begin
    fwd_d = fwd_q;
    rc_d  = rc_q;
    vb_d  = vb_q;
    if (accept && command_i == CMD_SEQ) begin
      if (last_i || !is_base) begin
        fwd_d = '0;
        rc_d  = '0;
        vb_d  = '0;
      end else begin
        fwd_d = fwd_n;
        rc_d  = rc_n;
        vb_d  = vb_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rc_q  <= '0;
      vb_q  <= '0;
    end else begin
      fwd_q <= fwd_d;
      rc_q  <= rc_d;
      vb_q  <= vb_d;
    end
  end

  // queue entry
  assign fwd_ext = CW'(fwd_n);
  assign rc_ext  = CW'(rc_n);

  always_comb begin
    entry_o          = '0;
    entry_o.word     = table_word_i;
    if (command_i == CMD_WRITE) begin
      entry_o.is_write = 1'b1;
      entry_o.fwd_idx  = table_address_i;
    end else begin
      entry_o.last     = last_i;
      entry_o.lookup   = is_base && (vb_n == k);
      entry_o.fwd_idx  = fwd_ext[IDX_CODE_W-1:BIT_SEL_W];
      entry_o.fwd_bit  = fwd_ext[BIT_SEL_W-1:0];
      entry_o.rc_idx   = rc_ext[IDX_CODE_W-1:BIT_SEL_W];
      entry_o.rc_bit   = rc_ext[BIT_SEL_W-1:0];
    end
  end

endmodule

### rtl/kbf_fifo.sv
`timescale 1ns / 1ps
module kbf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kbf_pkg::kbf_entry_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  output kbf_pkg::kbf_entry_t entry_o,
  input  logic                pop_i
);
  import kbf_pkg::*;

  kbf_entry_t        slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/kbf_back.sv
`timescale 1ns / 1ps
module kbf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  kbf_pkg::kbf_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o
);
  import kbf_pkg::*;

  logic [TBL_WORD_W-1:0] mem_q [TBL_DEPTH];
  logic [TBL_WORD_W-1:0] rd_fwd_q, rd_rc_q;

  logic                 s1_valid_q;
  logic                 s1_last_q;
  logic                 s1_lookup_q;
  logic [BIT_SEL_W-1:0] s1_fwd_bit_q, s1_rc_bit_q;

  logic out_valid_q, found_q, hit_seen_q;
  logic stall1, adv1, pop, wr_en, rd_en, hit;

  // stage 1 only waits when it carries a result and the output is full
  assign stall1 = s1_valid_q && s1_last_q && out_valid_q && !out_ready_i;
  assign adv1   = s1_valid_q && !stall1;
  assign pop    = q_valid_i && !stall1;
  assign wr_en  = pop && q_entry_i.is_write;
  assign rd_en  = pop && !q_entry_i.is_write;
  assign q_pop_o = pop;

  // membership table, one write or two reads per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[q_entry_i.fwd_idx] <= q_entry_i.word;
    end
    if (rd_en) begin
      rd_fwd_q <= mem_q[q_entry_i.fwd_idx];
      rd_rc_q  <= mem_q[q_entry_i.rc_idx];
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (!stall1) begin
      s1_last_q    <= q_entry_i.last;
      s1_lookup_q  <= q_entry_i.lookup;
      s1_fwd_bit_q <= q_entry_i.fwd_bit;
      s1_rc_bit_q  <= q_entry_i.rc_bit;
    end
  end

  // hit test on the two table words
  assign hit = s1_lookup_q && (rd_fwd_q[s1_fwd_bit_q] || rd_rc_q[s1_rc_bit_q]);

  // stage 1 valid, sticky flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      hit_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!stall1) begin
        s1_valid_q <= rd_en;
      end
      if (adv1) begin
        hit_seen_q <= s1_last_q ? 1'b0 : (hit_seen_q || hit);
      end
      if (adv1 && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s1_last_q) begin
      found_q <= hit_seen_q || hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

endmodule

### rtl/kmer_bitvector_read_filter.sv
`timescale 1ns / 1ps
// output path: found is valid once the read's last item has passed a queue slot, stage 1 and the output register
// throughput: one item per cycle unless the queue is full or the output stalls;
// the front updates k-mers combinationally, the back reads the table at both codes via two ports
// reset: per-read state, queue and output clear at once; word length resets to 10;
// the membership table is not cleared and must be written before lookups hit it
module kmer_bitvector_read_filter #(
  parameter int MAX_WORD_LENGTH = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kbf_pkg::WL_W-1:0]          cfg_wdata_i,    // word_length
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [kbf_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // base, table_address, table_word
  input  logic                              s_axis_tuser,   // command
  input  logic                              s_axis_tlast,   // last_of_read
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [kbf_pkg::M_TDATA_W-1:0]     m_axis_tdata    // found
);
  import kbf_pkg::*;

  kbf_entry_t push_entry, pop_entry;
  logic       push, full, q_valid, q_pop, found;

  kbf_front #(
    .MAX_WORD_LENGTH(MAX_WORD_LENGTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .command_i      (s_axis_tuser),
    .base_i         (s_axis_tdata[7:0]),
    .last_i         (s_axis_tlast),
    .table_address_i(s_axis_tdata[21:8]),
    .table_word_i   (s_axis_tdata[85:22]),
    .push_o         (push),
    .entry_o        (push_entry),
    .full_i         (full)
  );

  kbf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .valid_o(q_valid),
    .entry_o(pop_entry),
    .pop_i  (q_pop)
  );

  kbf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (pop_entry),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .found_o    (found)
  );

  assign m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, found};

  // table writes never trigger a lookup or end a read
  a_write_entry_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && push_entry.is_write |-> !push_entry.lookup && !push_entry.last)
    else $error("table write entry carries lookup or last");

  // the back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a full queue holds off the input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !s_axis_tready)
    else $error("input accepted while queue full");

endmodule
